// ===== rtl/rsfr_pkg.sv =====
// Shared types, codes and constants of the RS-485 frame receiver.
package rsfr_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PROGRESS = 3'd0,
    ST_PAYLOAD  = 3'd1,
    ST_GOOD     = 3'd2,
    ST_BAD      = 3'd3,
    ST_REJECT   = 3'd4
  } status_e;

  // Fixed frame bytes.
  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;
  localparam logic [7:0] FIXED_ZERO = 8'h00;

  // Reset value of the gateway address register.
  localparam logic [7:0] GATEWAY_RESET = 8'h01;

  // Frame byte positions, counted from 1.
  localparam logic [8:0] POS_HDR_FIRST     = 9'd1;
  localparam logic [8:0] POS_HDR_SECOND    = 9'd2;
  localparam logic [8:0] POS_SRC_HIGH      = 9'd3;
  localparam logic [8:0] POS_SRC_LOW       = 9'd4;
  localparam logic [8:0] POS_DST_HIGH      = 9'd5;
  localparam logic [8:0] POS_DST_LOW       = 9'd6;
  localparam logic [8:0] POS_CONTROL       = 9'd7;
  localparam logic [8:0] POS_FUNCTION      = 9'd8;
  localparam logic [8:0] FIRST_PAYLOAD_POS = 9'd10;

  // One received item.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       gap_before;
  } in_item_t;

  // One result item.
  typedef struct packed {
    status_e     status;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  source_address;
    logic [7:0]  control_code;
    logic [7:0]  function_code;
    logic [7:0]  data_length;
    logic [15:0] received_sum;
    logic [15:0] computed_sum;
  } out_item_t;

endpackage

// ===== rtl/rsfr_if.sv =====
// Valid/ready channel interfaces for received bytes and result items.
interface rsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       gap_before;

  modport source (output valid, output rx_byte, output gap_before, input ready);
  modport sink   (input valid, input rx_byte, input gap_before, output ready);
endinterface

interface rsfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [7:0]  source_address;
  logic [7:0]  control_code;
  logic [7:0]  function_code;
  logic [7:0]  data_length;
  logic [15:0] received_sum;
  logic [15:0] computed_sum;

  modport source (
    output valid, output status, output payload_byte, output payload_index,
    output source_address, output control_code, output function_code,
    output data_length, output received_sum, output computed_sum,
    input ready
  );
  modport sink (
    input valid, input status, input payload_byte, input payload_index,
    input source_address, input control_code, input function_code,
    input data_length, input received_sum, input computed_sum,
    output ready
  );
endinterface

// ===== rtl/rsfr_in_stage.sv =====
// Input register stage that captures one received item.
module rsfr_in_stage import rsfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  rsfr_in_if.sink  rx_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  // The register takes a new item when empty or when its item moves on.
  assign rx_i.ready = !valid_q || take_i;
  assign valid_d    = rx_i.ready ? rx_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      item_q.rx_byte    <= rx_i.rx_byte;
      item_q.gap_before <= rx_i.gap_before;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/rsfr_parser.sv =====
// Frame parser state, per-byte decode and the result register.
module rsfr_parser import rsfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] gateway_i,
  input  logic       valid_i,
  input  in_item_t   item_i,
  output logic       take_o,
  rsfr_out_if.source res_o
);

  logic [8:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  src_q, src_d;
  logic [7:0]  ctl_q, ctl_d;
  logic [7:0]  fun_q, fun_d;
  logic [7:0]  chk_q, chk_d;

  logic        res_valid_q;
  out_item_t   res_q, res_d;

  logic        fire;
  logic [8:0]  pos;
  logic [8:0]  end_pos;
  logic        fixed;
  logic [7:0]  expect_byte;
  logic [15:0] byte_ext;
  logic [15:0] rsum;

  // An item moves on when the result register is free or being drained.
  assign fire   = valid_i && (!res_valid_q || res_o.ready);
  assign take_o = fire;

  // Position of this byte in the frame, after an optional restart.
  assign pos      = (item_i.gap_before ? 9'd0 : pos_q) + 9'd1;
  assign end_pos  = FIRST_PAYLOAD_POS + {1'b0, len_q};
  assign byte_ext = {8'h00, item_i.rx_byte};
  assign rsum     = {chk_q, item_i.rx_byte};

  // Expected value of the fixed bytes.
  always_comb begin
    fixed       = 1'b1;
    expect_byte = FIXED_ZERO;
    unique case (pos)
      POS_HDR_FIRST:  expect_byte = HDR_FIRST;
      POS_HDR_SECOND: expect_byte = HDR_SECOND;
      POS_SRC_HIGH:   expect_byte = FIXED_ZERO;
      POS_DST_HIGH:   expect_byte = gateway_i;
      POS_DST_LOW:    expect_byte = FIXED_ZERO;
      default:        fixed = 1'b0;
    endcase
  end

  // Per-byte decode and next state.
  always_comb begin
    pos_d = pos;
    len_d = len_q;
    sum_d = sum_q;
    src_d = src_q;
    ctl_d = ctl_q;
    fun_d = fun_q;
    chk_d = chk_q;
    res_d = '0;
    res_d.status = ST_PROGRESS;

    if (fixed) begin
      if (item_i.rx_byte != expect_byte) begin
        res_d.status = ST_REJECT;
        pos_d        = '0;
      end else if (pos == POS_HDR_FIRST) begin
        sum_d = byte_ext;
      end else begin
        sum_d = sum_q + byte_ext;
      end
    end else if (pos < FIRST_PAYLOAD_POS) begin
      // Source low, control, function and length bytes.
      if (pos == POS_SRC_LOW) begin
        src_d = item_i.rx_byte;
      end else if (pos == POS_CONTROL) begin
        ctl_d = item_i.rx_byte;
      end else if (pos == POS_FUNCTION) begin
        fun_d = item_i.rx_byte;
      end else begin
        len_d = item_i.rx_byte;
      end
      sum_d = sum_q + byte_ext;
    end else if (pos < end_pos) begin
      res_d.status        = ST_PAYLOAD;
      res_d.payload_byte  = item_i.rx_byte;
      res_d.payload_index = 8'(pos - FIRST_PAYLOAD_POS);
      sum_d               = sum_q + byte_ext;
    end else if (pos == end_pos) begin
      chk_d = item_i.rx_byte;
    end else begin
      // Checksum low byte closes the frame.
      res_d.received_sum = rsum;
      res_d.status       = (rsum == sum_q) ? ST_GOOD : ST_BAD;
      pos_d              = '0;
    end

    res_d.source_address = src_d;
    res_d.control_code   = ctl_d;
    res_d.function_code  = fun_d;
    res_d.data_length    = len_d;
    res_d.computed_sum   = sum_d;
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      len_q <= '0;
      sum_q <= '0;
      src_q <= '0;
      ctl_q <= '0;
      fun_q <= '0;
      chk_q <= '0;
    end else if (fire) begin
      pos_q <= pos_d;
      len_q <= len_d;
      sum_q <= sum_d;
      src_q <= src_d;
      ctl_q <= ctl_d;
      fun_q <= fun_d;
      chk_q <= chk_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.status         = res_q.status;
  assign res_o.payload_byte   = res_q.payload_byte;
  assign res_o.payload_index  = res_q.payload_index;
  assign res_o.source_address = res_q.source_address;
  assign res_o.control_code   = res_q.control_code;
  assign res_o.function_code  = res_q.function_code;
  assign res_o.data_length    = res_q.data_length;
  assign res_o.received_sum   = res_q.received_sum;
  assign res_o.computed_sum   = res_q.computed_sum;

  // A rejected byte leaves the parser idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_d.status == ST_REJECT) |=> (pos_q == '0))
    else $error("parser not idle after a rejected byte");

  // The end of a frame leaves the parser idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (res_d.status == ST_GOOD || res_d.status == ST_BAD)) |=> (pos_q == '0))
    else $error("parser not idle after the checksum byte");

  // A payload index stays below the frame length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_d.status == ST_PAYLOAD) |-> (res_d.payload_index < res_d.data_length))
    else $error("payload index beyond frame length");

  // The position never runs past the checksum high byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= end_pos)
    else $error("byte position beyond frame end");

endmodule

// ===== rtl/rs485_frame_receiver_core.sv =====
// Top level of the RS-485 frame receiver: config register, input stage and parser.
//
// The rx_i channel carries one received byte per item, with gap_before set
// when an inter-character timeout came before it; the parser then restarts.
// The res_o channel returns exactly one result item for every byte: status,
// the payload byte and its index, the header fields of the current frame,
// and the received and computed checksums.
// The gateway address register is written through cfg_we_i and cfg_wdata_i;
// the user must write it only while the block is idle, which the block
// itself does not enforce. It resets to 1. A byte accepted on rx_i passes
// through the input register, then the decode and result register, to res_o.
// Throughput is one byte per cycle while res_o.ready stays high; the state update
// (an 8-bit compare, a 16-bit add and a 16-bit checksum compare) is combinational.
// Reset clears the parser to idle, the checksum and all header fields to
// zero, and empties both registers. When the consumer stalls, the result
// register holds its item, the input register takes one more byte, and then
// rx_i.ready drops until res_o drains.
module rs485_frame_receiver_core import rsfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  rsfr_in_if.sink    rx_i,
  rsfr_out_if.source res_o
);

  logic [7:0] gateway_q;
  logic       stage_valid;
  in_item_t   stage_item;
  logic       take;

  // Gateway address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gateway_q <= GATEWAY_RESET;
    end else if (cfg_we_i) begin
      gateway_q <= cfg_wdata_i;
    end
  end

  // Input register.
  rsfr_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .take_i  (take),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  // Decode and result register.
  rsfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .gateway_i (gateway_q),
    .valid_i   (stage_valid),
    .item_i    (stage_item),
    .take_o    (take),
    .res_o     (res_o)
  );

endmodule
